>>> rtl/broadcast_stride_offset_generator_macros.svh
// Assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef BROADCAST_STRIDE_OFFSET_GENERATOR_MACROS_SVH
`define BROADCAST_STRIDE_OFFSET_GENERATOR_MACROS_SVH

// same-cycle implication
`define BSOG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bsog assertion failed");

// next-cycle implication
`define BSOG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bsog assertion failed");

`endif

>>> rtl/bsog_pkg.sv
package bsog_pkg;

  localparam int unsigned FLAT_W       = 48;
  localparam int unsigned OFS_W        = 34;
  localparam int unsigned CFG_W        = 64;
  localparam int unsigned SLOT_W       = 16;
  localparam int unsigned RANK_W       = 3;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned MAX_RANK_DEF = 4;
  localparam int unsigned DIM_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUTPUT_RANK  = 3'd0,
    CFG_OUT_SHAPE    = 3'd1,
    CFG_LHS_RANK     = 3'd2,
    CFG_LHS_SHAPE    = 3'd3,
    CFG_LHS_STRIDE   = 3'd4,
    CFG_RHS_RANK     = 3'd5,
    CFG_RHS_SHAPE    = 3'd6,
    CFG_RHS_STRIDE   = 3'd7
  } cfg_reg_e;

  localparam logic [CFG_W-1:0] SHAPE_RST = 64'h0001_0001_0001_0001;

endpackage

>>> rtl/bsog_in_if.sv
interface bsog_in_if;
  import bsog_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLAT_W-1:0] flat_index;
  modport source (output valid, output flat_index, input ready);
  modport sink   (input valid, input flat_index, output ready);
endinterface

>>> rtl/bsog_out_if.sv
interface bsog_out_if;
  import bsog_pkg::*;
  logic              valid;
  logic              ready;
  logic [FLAT_W-1:0] out_offset;
  logic [OFS_W-1:0]  src0_offset;
  logic [OFS_W-1:0]  src1_offset;
  modport source (output valid, output out_offset, output src0_offset, output src1_offset,
                  input ready);
  modport sink   (input valid, input out_offset, input src0_offset, input src1_offset,
                  output ready);
endinterface

>>> rtl/bsog_axis_div.sv
module bsog_axis_div #(
  parameter int unsigned MAX_RANK = bsog_pkg::MAX_RANK_DEF,
  parameter int unsigned DIM_BITS = bsog_pkg::DIM_BITS_DEF,
  parameter int unsigned AXIS     = 0
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic [DIM_BITS-1:0]                    divisor_i,
  input  logic                                   valid_i,
  input  logic [bsog_pkg::FLAT_W-1:0]            flat_i,
  input  logic [bsog_pkg::FLAT_W-1:0]            num_i,
  input  logic [MAX_RANK-1:0][DIM_BITS-1:0]      coord_i,
  output logic                                   valid_o,
  output logic [bsog_pkg::FLAT_W-1:0]            flat_o,
  output logic [bsog_pkg::FLAT_W-1:0]            quot_o,
  output logic [MAX_RANK-1:0][DIM_BITS-1:0]      coord_o
);
  import bsog_pkg::*;

  // one quotient bit per stage, restoring
  logic [FLAT_W-1:0]                           valid_q, src_valid;
  logic [FLAT_W-1:0][FLAT_W-1:0]               flat_q, src_flat, nq_q, src_nq;
  logic [FLAT_W-1:0][DIM_BITS-1:0]             rem_q, src_rem;
  logic [FLAT_W-1:0][MAX_RANK-1:0][DIM_BITS-1:0] coord_q, src_coord;

  for (genvar k = 0; k < FLAT_W; k++) begin : g_stage
    logic [DIM_BITS:0] ext, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign src_valid[k] = valid_i;
      assign src_flat[k]  = flat_i;
      assign src_nq[k]    = num_i;
      assign src_rem[k]   = '0;
      assign src_coord[k] = coord_i;
    end else begin : g_next
      assign src_valid[k] = valid_q[k-1];
      assign src_flat[k]  = flat_q[k-1];
      assign src_nq[k]    = nq_q[k-1];
      assign src_rem[k]   = rem_q[k-1];
      assign src_coord[k] = coord_q[k-1];
    end

    assign ext  = {src_rem[k], src_nq[k][FLAT_W-1]};
    assign diff = ext - {1'b0, divisor_i};
    assign ge   = (ext >= {1'b0, divisor_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= src_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flat_q[k]  <= src_flat[k];
        nq_q[k]    <= {src_nq[k][FLAT_W-2:0], ge};
        rem_q[k]   <= ge ? diff[DIM_BITS-1:0] : ext[DIM_BITS-1:0];
        coord_q[k] <= src_coord[k];
      end
    end
  end

  always_comb begin
    coord_o       = coord_q[FLAT_W-1];
    coord_o[AXIS] = rem_q[FLAT_W-1];
  end

  assign valid_o = valid_q[FLAT_W-1];
  assign flat_o  = flat_q[FLAT_W-1];
  assign quot_o  = nq_q[FLAT_W-1];

endmodule

>>> rtl/bsog_offset_map.sv
module bsog_offset_map #(
  parameter int unsigned MAX_RANK = bsog_pkg::MAX_RANK_DEF,
  parameter int unsigned DIM_BITS = bsog_pkg::DIM_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [bsog_pkg::RANK_W-1:0]         orank_i,
  input  logic [bsog_pkg::RANK_W-1:0]         srank_i,
  input  logic [bsog_pkg::CFG_W-1:0]          shape_i,
  input  logic [bsog_pkg::CFG_W-1:0]          stride_i,
  input  logic [MAX_RANK-1:0][DIM_BITS-1:0]   coord_i,
  output logic [bsog_pkg::OFS_W-1:0]          offset_o
);
  import bsog_pkg::*;

  logic [RANK_W-1:0]                      skip;
  logic [MAX_RANK-1:0][2*DIM_BITS-1:0]    term_d, term_q;
  logic [OFS_W-1:0]                       sum_d, sum_q;

  assign skip = orank_i - srank_i;

  for (genvar a = 0; a < MAX_RANK; a++) begin : g_axis
    logic [RANK_W-1:0]   ax, sa;
    logic [1:0]          slot;
    logic [DIM_BITS-1:0] sdim, sstr;
    logic                used;

    assign ax   = RANK_W'(a);
    assign sa   = ax - skip;
    assign slot = sa[1:0];
    assign sdim = shape_i[slot*SLOT_W +: DIM_BITS];
    assign sstr = stride_i[slot*SLOT_W +: DIM_BITS];
    assign used = (ax < orank_i) && (ax >= skip) && (sdim != DIM_BITS'(1));
    assign term_d[a] = used ? coord_i[a] * sstr : '0;
  end

  always_comb begin
    sum_d = '0;
    for (int a = 0; a < MAX_RANK; a++) begin
      sum_d = sum_d + OFS_W'(term_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      term_q <= term_d;
      sum_q  <= sum_d;
    end
  end

  assign offset_o = sum_q;

endmodule

>>> rtl/broadcast_stride_offset_generator.sv
// Broadcast stride offset generator.
// in_i carries one flat output element index per word; out_o gives the output
// offset (the index itself) and the element offsets into the two sources.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i, only while
// no word is in flight; the user must keep to this, the block does not enforce
// it. Register index follows the order rank, output shape, lhs rank/shape/stride,
// rhs rank/shape/stride. Throughput: one word per cycle while the receiver
// takes results; a stall holds the whole pipeline. The result passes through
// the chain of per-axis dividers, each retiring one quotient bit per stage,
// followed by a multiply stage and a sum stage.
// Reset clears all valid bits and restores ranks of one, unit shapes and zero
// strides. When the receiver holds ready low with a word waiting, the whole
// pipeline freezes and in_i.ready drops in the same cycle; nothing is lost or
// repeated.
module broadcast_stride_offset_generator #(
  parameter int unsigned MAX_RANK = bsog_pkg::MAX_RANK_DEF,
  parameter int unsigned DIM_BITS = bsog_pkg::DIM_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bsog_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bsog_pkg::CFG_W-1:0]    cfg_data_i,
  bsog_in_if.sink                       in_i,
  bsog_out_if.source                    out_o
);
  import bsog_pkg::*;
  `include "broadcast_stride_offset_generator_macros.svh"

  logic [RANK_W-1:0] output_rank_q, lhs_rank_q, rhs_rank_q;
  logic [CFG_W-1:0]  out_shape_q, lhs_shape_q, lhs_stride_q, rhs_shape_q, rhs_stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      output_rank_q <= RANK_W'(1);
      out_shape_q   <= SHAPE_RST;
      lhs_rank_q    <= RANK_W'(1);
      lhs_shape_q   <= SHAPE_RST;
      lhs_stride_q  <= '0;
      rhs_rank_q    <= RANK_W'(1);
      rhs_shape_q   <= SHAPE_RST;
      rhs_stride_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_OUTPUT_RANK: output_rank_q <= cfg_data_i[RANK_W-1:0];
        CFG_OUT_SHAPE:   out_shape_q   <= cfg_data_i;
        CFG_LHS_RANK:    lhs_rank_q    <= cfg_data_i[RANK_W-1:0];
        CFG_LHS_SHAPE:   lhs_shape_q   <= cfg_data_i;
        CFG_LHS_STRIDE:  lhs_stride_q  <= cfg_data_i;
        CFG_RHS_RANK:    rhs_rank_q    <= cfg_data_i[RANK_W-1:0];
        CFG_RHS_SHAPE:   rhs_shape_q   <= cfg_data_i;
        CFG_RHS_STRIDE:  rhs_stride_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // saturated ranks
  logic [RANK_W-1:0] orank, lrank, rrank;

  always_comb begin
    priority if (output_rank_q == '0)                 orank = RANK_W'(1);
    else if (output_rank_q > RANK_W'(MAX_RANK))       orank = RANK_W'(MAX_RANK);
    else                                              orank = output_rank_q;
    priority if (lhs_rank_q == '0)                    lrank = RANK_W'(1);
    else if (lhs_rank_q > orank)                      lrank = orank;
    else                                              lrank = lhs_rank_q;
    priority if (rhs_rank_q == '0)                    rrank = RANK_W'(1);
    else if (rhs_rank_q > orank)                      rrank = orank;
    else                                              rrank = rhs_rank_q;
  end

  logic en;
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // divider chain, highest axis first
  logic [MAX_RANK:0]                              v_c;
  logic [MAX_RANK:0][FLAT_W-1:0]                  flat_c, num_c;
  logic [MAX_RANK:0][MAX_RANK-1:0][DIM_BITS-1:0]  coord_c;

  assign v_c[0]     = in_i.valid && in_i.ready;
  assign flat_c[0]  = in_i.flat_index;
  assign num_c[0]   = in_i.flat_index;
  assign coord_c[0] = '0;

  for (genvar j = 0; j < MAX_RANK; j++) begin : g_div
    localparam int unsigned AX = MAX_RANK - 1 - j;
    logic [DIM_BITS-1:0] dim, divisor;

    assign dim     = out_shape_q[AX*SLOT_W +: DIM_BITS];
    assign divisor = (RANK_W'(AX) < orank && dim != '0) ? dim : DIM_BITS'(1);

    bsog_axis_div #(
      .MAX_RANK (MAX_RANK),
      .DIM_BITS (DIM_BITS),
      .AXIS     (AX)
    ) u_div (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .divisor_i (divisor),
      .valid_i   (v_c[j]),
      .flat_i    (flat_c[j]),
      .num_i     (num_c[j]),
      .coord_i   (coord_c[j]),
      .valid_o   (v_c[j+1]),
      .flat_o    (flat_c[j+1]),
      .quot_o    (num_c[j+1]),
      .coord_o   (coord_c[j+1])
    );
  end

  bsog_offset_map #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS)
  ) u_lhs (
    .clk_i    (clk_i),
    .en_i     (en),
    .orank_i  (orank),
    .srank_i  (lrank),
    .shape_i  (lhs_shape_q),
    .stride_i (lhs_stride_q),
    .coord_i  (coord_c[MAX_RANK]),
    .offset_o (out_o.src0_offset)
  );

  bsog_offset_map #(
    .MAX_RANK (MAX_RANK),
    .DIM_BITS (DIM_BITS)
  ) u_rhs (
    .clk_i    (clk_i),
    .en_i     (en),
    .orank_i  (orank),
    .srank_i  (rrank),
    .shape_i  (rhs_shape_q),
    .stride_i (rhs_stride_q),
    .coord_i  (coord_c[MAX_RANK]),
    .offset_o (out_o.src1_offset)
  );

  // valid and index alongside the multiply and sum stages
  logic              v_mul_q, v_sum_q;
  logic [FLAT_W-1:0] flat_mul_q, flat_sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_mul_q <= 1'b0;
      v_sum_q <= 1'b0;
    end else if (en) begin
      v_mul_q <= v_c[MAX_RANK];
      v_sum_q <= v_mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      flat_mul_q <= flat_c[MAX_RANK];
      flat_sum_q <= flat_mul_q;
    end
  end

  assign out_o.valid      = v_sum_q;
  assign out_o.out_offset = flat_sum_q;

  `BSOG_ASSERT_NOW(a_stall_blocks_intake, out_o.valid && !out_o.ready, !in_i.ready)
  `BSOG_ASSERT_NEXT(a_stalled_word_held, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.out_offset))
  `BSOG_ASSERT_NOW(a_out_moves_only_enabled, $rose(v_sum_q), $past(en))

endmodule
